### rtl/sld_pkg.sv
// Shared types and constants for the simplex list difference matcher.
package sld_pkg;

    localparam int TABLE_DEPTH  = 32;
    localparam int MAX_VERTICES = 4;
    localparam int VERTEX_BITS  = 16;
    localparam int QUERY_LIMIT  = 1024;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int QCNT_W = $clog2(QUERY_LIMIT + 1);

    localparam int PORT_VERTICES = 4;
    localparam int PORT_VBITS    = 16;
    localparam int FIRST_W       = 10;
    localparam int SECOND_W      = 5;
    localparam int SIZE_W        = 3;

    typedef logic [MAX_VERTICES-1:0][VERTEX_BITS-1:0] entry_t;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_FLUSH = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CAT_INTER = 3'd0,
        CAT_DEL   = 3'd1,
        CAT_ADD   = 3'd2,
        CAT_DONE  = 3'd3,
        CAT_OVF   = 3'd4
    } cat_t;

    typedef struct packed {
        logic                    load_en;
        logic                    query_en;
        logic                    shift_en;
        logic [IDX_W-1:0]        load_idx;
        logic [MAX_VERTICES-1:0] vmask;
        entry_t                  key;
    } ctrl_t;

endpackage

### rtl/sld_cell.sv
// One table cell: stores an entry, compares it with a query and shifts its status down.
module sld_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [sld_pkg::IDX_W-1:0] cell_idx,
    input  sld_pkg::ctrl_t           ctrl,
    input  logic                     up_valid,
    input  logic                     up_matched,
    output logic                     valid,
    output logic                     matched,
    output logic                     hit
);
    import sld_pkg::*;

    entry_t entry_reg;
    logic   valid_reg;
    logic   matched_reg;
    logic   hit_reg;
    logic   sel;
    logic   eq;

    assign sel = ctrl.load_en && (ctrl.load_idx == cell_idx);

    always_comb
    begin
        eq = 1'b1;
        for (int v = 0; v < MAX_VERTICES; v++)
        begin
            if (ctrl.vmask[v] && (entry_reg[v] != ctrl.key[v]))
            begin
                eq = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            entry_reg <= ctrl.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            matched_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else if (ctrl.shift_en)
        begin
            valid_reg   <= up_valid;
            matched_reg <= up_matched;
        end
        else if (sel)
        begin
            valid_reg   <= 1'b1;
            matched_reg <= 1'b0;
        end
        else if (ctrl.query_en)
        begin
            hit_reg     <= valid_reg && eq;
            matched_reg <= matched_reg || (valid_reg && eq);
        end
    end

    assign valid   = valid_reg;
    assign matched = matched_reg;
    assign hit     = hit_reg;

endmodule

### rtl/simplex_list_diff_match.sv
// Top level of the simplex list difference matcher: control, output register and cell row.
// A load gives no word unless the table is full. A query compares against every cell at
// once as it is taken and registers the hits; it then places its word after a priority
// encode once the output register is free or drains, and waits in S_QRES while a waiting
// word is stalled; an overflow behaves the same. A flush shifts the cell status down the
// row one cell per cycle while no word that it found at cell zero is stalled, reads it at
// cell zero, and places the done word once the whole row has been shifted out. Input is
// taken only while no item is at work; a finished word may still wait in the output
// register. The vertex store has no reset and needs no clearing pass.
module simplex_list_diff_match (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sld_pkg::SIZE_W-1:0]      cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      kind,
    input  logic [sld_pkg::PORT_VBITS-1:0]  vertex_0,
    input  logic [sld_pkg::PORT_VBITS-1:0]  vertex_1,
    input  logic [sld_pkg::PORT_VBITS-1:0]  vertex_2,
    input  logic [sld_pkg::PORT_VBITS-1:0]  vertex_3,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      category,
    output logic [sld_pkg::FIRST_W-1:0]     first_index,
    output logic [sld_pkg::SECOND_W-1:0]    second_index,
    output logic                            last
);
    import sld_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QRES,
        S_OVF,
        S_FLUSH,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [CNT_W-1:0]     load_count_reg;
    logic [QCNT_W-1:0]    query_count_reg;
    logic [CNT_W-1:0]     flush_cnt_reg;
    logic                 out_valid_reg;
    cat_t                 category_reg;
    logic [FIRST_W-1:0]   first_reg;
    logic [SECOND_W-1:0]  second_reg;
    logic                 last_reg;

    ctrl_t                ctrl;
    logic                 accept;
    logic                 slot_free;
    logic                 load_full;
    logic                 query_full;
    logic                 pending;
    logic                 out_load;
    logic [SIZE_W-1:0]    size_eff;
    logic [PORT_VERTICES-1:0][PORT_VBITS-1:0] vin;
    logic [TABLE_DEPTH-1:0] cell_valid;
    logic [TABLE_DEPTH-1:0] cell_matched;
    logic [TABLE_DEPTH-1:0] cell_hit;
    logic [IDX_W-1:0]     hit_idx;

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign slot_free  = !out_valid_reg || out_ready;
    assign load_full  = (load_count_reg >= CNT_W'(TABLE_DEPTH));
    assign query_full = (query_count_reg >= QCNT_W'(QUERY_LIMIT));
    assign pending    = cell_valid[0] && !cell_matched[0];
    assign size_eff   = (size_reg == '0) ? SIZE_W'(1) : size_reg;
    assign vin        = {vertex_3, vertex_2, vertex_1, vertex_0};
    assign out_load   = ((state_reg == S_QRES || state_reg == S_OVF || state_reg == S_DONE)
                         && slot_free) || (ctrl.shift_en && pending);

    always_comb
    begin
        ctrl.load_en  = accept && (kind_t'(kind) == KIND_LOAD) && !load_full;
        ctrl.query_en = accept && (kind_t'(kind) == KIND_QUERY) && !query_full;
        ctrl.shift_en = (state_reg == S_FLUSH) && (!pending || slot_free);
        ctrl.load_idx = load_count_reg[IDX_W-1:0];
        for (int v = 0; v < MAX_VERTICES; v++)
        begin
            ctrl.vmask[v] = (SIZE_W'(v) < size_eff);
            ctrl.key[v]   = vin[v][VERTEX_BITS-1:0];
        end
    end

    always_comb
    begin
        hit_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (cell_hit[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic up_v;
        logic up_m;
        if (i == TABLE_DEPTH - 1)
        begin : g_end
            assign up_v = 1'b0;
            assign up_m = 1'b0;
        end
        else
        begin : g_mid
            assign up_v = cell_valid[i+1];
            assign up_m = cell_matched[i+1];
        end
        sld_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (IDX_W'(i)),
            .ctrl       (ctrl),
            .up_valid   (up_v),
            .up_matched (up_m),
            .valid      (cell_valid[i]),
            .matched    (cell_matched[i]),
            .hit        (cell_hit[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_W'(1);
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            load_count_reg  <= '0;
            query_count_reg <= '0;
            flush_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
            category_reg    <= CAT_INTER;
            first_reg       <= '0;
            second_reg      <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (kind_t'(kind))
                            KIND_LOAD:
                            begin
                                if (load_full)
                                begin
                                    state_reg <= S_OVF;
                                end
                                else
                                begin
                                    load_count_reg <= load_count_reg + CNT_W'(1);
                                end
                            end
                            KIND_QUERY:
                            begin
                                state_reg <= query_full ? S_OVF : S_QRES;
                            end
                            KIND_FLUSH:
                            begin
                                state_reg       <= S_FLUSH;
                                flush_cnt_reg   <= '0;
                                load_count_reg  <= '0;
                                query_count_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_QRES:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        category_reg    <= (|cell_hit) ? CAT_INTER : CAT_DEL;
                        first_reg       <= FIRST_W'(query_count_reg);
                        second_reg      <= (|cell_hit) ? SECOND_W'(hit_idx) : '0;
                        last_reg        <= 1'b0;
                        query_count_reg <= query_count_reg + QCNT_W'(1);
                        state_reg       <= S_IDLE;
                    end
                end
                S_OVF:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        category_reg  <= CAT_OVF;
                        first_reg     <= '0;
                        second_reg    <= '0;
                        last_reg      <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                S_FLUSH:
                begin
                    if (ctrl.shift_en)
                    begin
                        if (pending)
                        begin
                            out_valid_reg <= 1'b1;
                            category_reg  <= CAT_ADD;
                            first_reg     <= '0;
                            second_reg    <= SECOND_W'(flush_cnt_reg[IDX_W-1:0]);
                            last_reg      <= 1'b0;
                        end
                        flush_cnt_reg <= flush_cnt_reg + CNT_W'(1);
                        if (flush_cnt_reg == CNT_W'(TABLE_DEPTH - 1))
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        category_reg  <= CAT_DONE;
                        first_reg     <= '0;
                        second_reg    <= '0;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign category     = category_reg;
    assign first_index  = first_reg;
    assign second_index = second_reg;
    assign last         = last_reg;

    a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind_t'(kind) == KIND_FLUSH)) |=> !in_ready)
        else $error("input taken during a flush");

    a_flush_counters: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> (load_count_reg == '0 && query_count_reg == '0))
        else $error("counters not cleared during a flush");

    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (cell_valid == '0))
        else $error("table not empty at the done word");

    a_query_cat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QRES && slot_free) |=>
        (out_valid_reg && ((category_reg == CAT_INTER) == $past(|cell_hit))))
        else $error("query word category disagrees with the cell hits");

endmodule

### tb/tb.sv
// Self-checking testbench for the simplex list difference matcher with a scoreboard class.
`timescale 1ns / 100ps

module tb;
    import sld_pkg::*;

    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int TOTAL_ITEMS   = 370;
    localparam int FULL_QUERIES  = 40;
    localparam logic [PORT_VBITS-1:0] VMASK = PORT_VBITS'((64'd1 << VERTEX_BITS) - 1);

    typedef logic [PORT_VERTICES-1:0][PORT_VBITS-1:0] simplex_t;

    typedef struct {
        cat_t                category;
        logic [FIRST_W-1:0]  first_index;
        logic [SECOND_W-1:0] second_index;
        logic                last;
    } diff_word_t;

    class list_diff_tracker;
        simplex_t               stored [TABLE_DEPTH];
        logic [TABLE_DEPTH-1:0] held;
        logic [TABLE_DEPTH-1:0] matched;
        int                     load_count;
        int                     query_count;
        logic [SIZE_W-1:0]      size_reg;
        diff_word_t             awaited_words [$];
        int                     mismatches;

        function new();
            held        = '0;
            matched     = '0;
            load_count  = 0;
            query_count = 0;
            size_reg    = SIZE_W'(1);
            mismatches  = 0;
        endfunction

        function void queue_word(cat_t c, int fi, int si, logic l);
            diff_word_t w;
            w.category     = c;
            w.first_index  = FIRST_W'(fi);
            w.second_index = SECOND_W'(si);
            w.last         = l;
            awaited_words.push_back(w);
        endfunction

        function void accept_item(kind_t k, simplex_t verts);
            simplex_t    key;
            logic [63:0] cmask;
            int          span;
            bit          found;
            int          first_hit;
            for (int i = 0; i < PORT_VERTICES; i++)
                key[i] = verts[i] & VMASK;
            span = (size_reg == 0) ? 1 : ((size_reg > MAX_VERTICES) ? MAX_VERTICES : size_reg);
            cmask = '0;
            for (int i = 0; i < MAX_VERTICES; i++)
                if (i < span)
                    cmask[PORT_VBITS*i +: PORT_VBITS] = '1;
            case (k)
                KIND_LOAD:
                    if (load_count >= TABLE_DEPTH)
                        queue_word(CAT_OVF, 0, 0, 1'b0);
                    else
                    begin
                        stored[load_count]  = key;
                        held[load_count]    = 1'b1;
                        matched[load_count] = 1'b0;
                        load_count++;
                    end
                KIND_QUERY:
                    if (query_count >= QUERY_LIMIT)
                        queue_word(CAT_OVF, 0, 0, 1'b0);
                    else
                    begin
                        found     = 1'b0;
                        first_hit = 0;
                        for (int i = 0; i < TABLE_DEPTH; i++)
                            if (held[i] && ((stored[i] & cmask) == (key & cmask)))
                            begin
                                if (!found)
                                begin
                                    found     = 1'b1;
                                    first_hit = i;
                                end
                                matched[i] = 1'b1;
                            end
                        if (found)
                            queue_word(CAT_INTER, query_count, first_hit, 1'b0);
                        else
                            queue_word(CAT_DEL, query_count, 0, 1'b0);
                        query_count++;
                    end
                KIND_FLUSH:
                begin
                    for (int i = 0; i < TABLE_DEPTH; i++)
                        if (held[i] && !matched[i])
                            queue_word(CAT_ADD, 0, i, 1'b0);
                    queue_word(CAT_DONE, 0, 0, 1'b1);
                    held        = '0;
                    matched     = '0;
                    load_count  = 0;
                    query_count = 0;
                end
                default:
                    ;
            endcase
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= 50)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_word(logic [2:0] cat, logic [FIRST_W-1:0] fi, logic [SECOND_W-1:0] si,
                        logic l);
            diff_word_t want;
            if (awaited_words.size() == 0)
            begin
                report_mismatch($sformatf(
                    "unexpected word: category %0d first %0d second %0d last %0d",
                    cat, fi, si, l));
                return;
            end
            want = awaited_words.pop_front();
            if (cat !== want.category)
                report_mismatch($sformatf("category %0d, wanted %0d", cat, want.category));
            if (fi !== want.first_index)
                report_mismatch($sformatf("first_index %0d, wanted %0d", fi, want.first_index));
            if (si !== want.second_index)
                report_mismatch($sformatf("second_index %0d, wanted %0d", si, want.second_index));
            if (l !== want.last)
                report_mismatch($sformatf("last %0d, wanted %0d", l, want.last));
        endtask
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [SIZE_W-1:0]     cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [1:0]            kind      = '0;
    logic [PORT_VBITS-1:0] vertex_0  = '0;
    logic [PORT_VBITS-1:0] vertex_1  = '0;
    logic [PORT_VBITS-1:0] vertex_2  = '0;
    logic [PORT_VBITS-1:0] vertex_3  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [2:0]            category;
    logic [FIRST_W-1:0]    first_index;
    logic [SECOND_W-1:0]   second_index;
    logic                  last;

    list_diff_tracker tracker = new();
    int cycle_count = 0;
    int rx_tick     = 0;
    int burst_left  = 0;
    int items_sent  = 0;

    simplex_list_diff_match dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .vertex_0     (vertex_0),
        .vertex_1     (vertex_1),
        .vertex_2     (vertex_2),
        .vertex_3     (vertex_3),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .category     (category),
        .first_index  (first_index),
        .second_index (second_index),
        .last         (last)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                tracker.check_word(category, first_index, second_index, last);
            rx_tick <= rx_tick + 1;
            case ((rx_tick / 97) % 3)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 9) < 7);
                default: out_ready <= ((rx_tick % 11) > 3);
            endcase
        end
    end

    function automatic logic [PORT_VBITS-1:0] pick_vertex();
        case ($urandom_range(0, 7))
            0, 1:    return PORT_VBITS'($urandom_range(0, 3));
            2:       return '1;
            3:       return '0;
            default: return PORT_VBITS'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic simplex_t pick_simplex();
        simplex_t r;
        for (int i = 0; i < PORT_VERTICES; i++)
            r[i] = pick_vertex();
        return r;
    endfunction

    // The leading vertices are kept, so whether this matches depends on the size in force.
    function automatic simplex_t near_copy(input simplex_t s);
        simplex_t r;
        int       keep;
        r    = s;
        keep = $urandom_range(1, PORT_VERTICES);
        for (int i = 0; i < PORT_VERTICES; i++)
            if (i >= keep)
                r[i] = pick_vertex();
        return r;
    endfunction

    task automatic send_item(input kind_t k, input simplex_t verts);
        in_valid <= 1'b1;
        kind     <= k;
        vertex_0 <= verts[0];
        vertex_1 <= verts[1];
        vertex_2 <= verts[2];
        vertex_3 <= verts[3];
        do
            @(posedge clk);
        while (!in_ready);
        tracker.accept_item(k, verts);
        if (k != KIND_NONE)
            items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
        end
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        while (tracker.awaited_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] value);
        settle_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.size_reg = value;
    endtask

    initial
    begin
        simplex_t loaded [$];
        simplex_t s;
        int       round;
        int       n_loads;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty flush, duplicates, size clamping and a size change mid-run.
        send_item(KIND_FLUSH, '0);
        write_size(SIZE_W'(4));
        send_item(KIND_LOAD, '1);
        send_item(KIND_LOAD, '0);
        send_item(KIND_LOAD, '1);
        send_item(KIND_LOAD, {16'd4, 16'd3, 16'd2, 16'd1});
        send_item(KIND_QUERY, '1);
        send_item(KIND_QUERY, {16'd9, 16'd3, 16'd2, 16'd1});
        send_item(KIND_NONE, '1);
        send_item(KIND_QUERY, '0);
        send_item(KIND_FLUSH, '0);
        write_size(SIZE_W'(0));
        send_item(KIND_QUERY, {16'd1, 16'd2, 16'd3, 16'd5});
        send_item(KIND_LOAD, {16'hAAAA, 16'h5555, 16'h1234, 16'd5});
        send_item(KIND_LOAD, {16'hAAAA, 16'h5555, 16'h1234, 16'd6});
        send_item(KIND_QUERY, {16'h0F0F, 16'hF0F0, 16'h8000, 16'd5});
        send_item(KIND_FLUSH, '1);
        write_size(SIZE_W'(7));
        send_item(KIND_LOAD, {16'd4, 16'd3, 16'd2, 16'd1});
        send_item(KIND_QUERY, {16'd5, 16'd3, 16'd2, 16'd1});
        write_size(SIZE_W'(3));
        send_item(KIND_QUERY, {16'd5, 16'd3, 16'd2, 16'd1});
        send_item(KIND_FLUSH, '0);

        // Full table, then a run of queries against it.
        write_size(SIZE_W'(2));
        loaded.delete();
        repeat (TABLE_DEPTH + 1)
        begin
            s = pick_simplex();
            loaded.push_back(s);
            send_item(KIND_LOAD, s);
        end
        repeat (FULL_QUERIES)
        begin
            if ($urandom_range(0, 9) < 3)
                s = near_copy(loaded[$urandom_range(0, TABLE_DEPTH - 1)]);
            else
                s = pick_simplex();
            send_item(KIND_QUERY, s);
        end
        send_item(KIND_LOAD, pick_simplex());
        send_item(KIND_FLUSH, pick_simplex());

        // Random rounds of loads, queries and a flush, with some noise and missing flushes.
        round = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            loaded.delete();
            if (round < 8)
                write_size(SIZE_W'(round));
            else if ($urandom_range(0, 1) == 0)
                write_size(SIZE_W'($urandom_range(0, 7)));
            n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 12);
            repeat (n_loads)
            begin
                if (loaded.size() > 0 && $urandom_range(0, 4) == 0)
                    s = loaded[$urandom_range(0, loaded.size() - 1)];
                else
                    s = pick_simplex();
                loaded.push_back(s);
                send_item(KIND_LOAD, s);
            end
            if ($urandom_range(0, 4) == 0)
                write_size(SIZE_W'($urandom_range(0, 7)));
            repeat ($urandom_range(1, 16))
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2:
                    begin
                        s = pick_simplex();
                        loaded.push_back(s);
                        send_item(KIND_LOAD, s);
                    end
                    3:
                        send_item(KIND_NONE, pick_simplex());
                    default:
                    begin
                        if (loaded.size() > 0 && $urandom_range(0, 9) < 6)
                            s = near_copy(loaded[$urandom_range(0, loaded.size() - 1)]);
                        else
                            s = pick_simplex();
                        send_item(KIND_QUERY, s);
                    end
                endcase
            end
            if ($urandom_range(0, 7) != 0)
                send_item(KIND_FLUSH, pick_simplex());
            round++;
        end

        settle_idle();
        if (tracker.awaited_words.size() != 0)
            tracker.report_mismatch("words still awaited at end of run");
        if (tracker.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
